// ===== src/ldrst_pkg.sv =====
// Shared types and constants for the light-sensor solar tracker step unit.
// No dependencies; every other file of the block refers to this package by scoped names.
package ldrst_pkg;

  // Batch size and converter resolution.
  localparam int SAMPLES     = 16;
  localparam int SAMPLE_BITS = 12;

  // Field widths of the stream payloads.
  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 12;
  localparam int ANGLE_W  = 8;
  localparam int THR_W    = 12;
  localparam int STEP_W   = 7;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // Accumulator and batch counter widths.
  localparam int SUM_W   = SAMPLE_BITS + $clog2(SAMPLES);
  localparam int COUNT_W = $clog2(SAMPLES + 1);

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Angle limits and reset values.
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = ANGLE_W'(90);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(100);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(10);

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP      = 1'b1;
  localparam int CFG_DATA_W = 12;

  typedef struct packed {
    logic [AVG_W-1:0] avg_four;
    logic [AVG_W-1:0] avg_three;
    logic [AVG_W-1:0] avg_two;
    logic [AVG_W-1:0] avg_one;
  } avg_set_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [STEP_W-1:0] step_degrees;
  } cfg_t;

  typedef struct packed {
    avg_set_t          avgs;
    logic [ANGLE_W-1:0] vertical;
    logic [ANGLE_W-1:0] horizontal;
  } result_t;

endpackage

// ===== src/ldrst_front.sv =====
// Front end: accepts sample sets, accumulates the four channel sums and
// pushes the batch averages into the queue at the end of each batch. Uses ldrst_pkg.
module ldrst_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ldrst_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                  q_full,
  output logic                                  q_push,
  output ldrst_pkg::avg_set_t                   q_data
);

  logic [ldrst_pkg::SUM_W-1:0]   sums [4];
  logic [ldrst_pkg::SUM_W-1:0]   sum_next [4];
  logic [ldrst_pkg::COUNT_W-1:0] count;
  logic                          accept;
  logic                          last;
  logic [ldrst_pkg::AVG_W-1:0]   avg [4];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign last     = (count == ldrst_pkg::COUNT_W'(ldrst_pkg::SAMPLES - 1));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      // keep only the converter's resolution
      sum_next[i] = sums[i] + ldrst_pkg::SUM_W'(
          s_tdata[i*ldrst_pkg::SAMPLE_W +: ldrst_pkg::SAMPLE_BITS]);
      avg[i] = ldrst_pkg::AVG_W'(sum_next[i] / ldrst_pkg::SUM_W'(ldrst_pkg::SAMPLES));
    end
  end

  assign q_push             = accept && last;
  assign q_data.avg_one     = avg[0];
  assign q_data.avg_two     = avg[1];
  assign q_data.avg_three   = avg[2];
  assign q_data.avg_four    = avg[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < 4; i++) sums[i] <= '0;
    end else if (accept) begin
      if (last) begin
        count <= '0;
        for (int i = 0; i < 4; i++) sums[i] <= '0;
      end else begin
        count <= count + 1'b1;
        for (int i = 0; i < 4; i++) sums[i] <= sum_next[i];
      end
    end
  end

endmodule

// ===== src/ldrst_fifo.sv =====
// Short queue of batch averages between front and back end.
// Uses ldrst_pkg for the entry type and depth.
module ldrst_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ldrst_pkg::avg_set_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output ldrst_pkg::avg_set_t pop_data
);

  ldrst_pkg::avg_set_t          entries [ldrst_pkg::QUEUE_DEPTH];
  logic [ldrst_pkg::QPTR_W-1:0] wr_ptr;
  logic [ldrst_pkg::QPTR_W-1:0] rd_ptr;
  logic [ldrst_pkg::QCNT_W-1:0] fill;
  logic                         do_push;
  logic                         do_pop;

  assign full     = (fill == ldrst_pkg::QCNT_W'(ldrst_pkg::QUEUE_DEPTH));
  assign valid    = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/ldrst_back.sv =====
// Back end: takes batch averages from the queue, decides both servo moves,
// holds the two angles and the registered result. Uses ldrst_pkg.
module ldrst_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ldrst_pkg::cfg_t      cfg,
  input  logic                 q_valid,
  input  ldrst_pkg::avg_set_t  q_data,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ldrst_pkg::result_t   res
);

  logic [ldrst_pkg::ANGLE_W-1:0] vert_pos;
  logic [ldrst_pkg::ANGLE_W-1:0] horz_pos;
  logic [ldrst_pkg::ANGLE_W-1:0] vert_next;
  logic [ldrst_pkg::ANGLE_W-1:0] horz_next;

  function automatic logic exceeds(input logic [ldrst_pkg::AVG_W-1:0] a,
                                   input logic [ldrst_pkg::AVG_W-1:0] b,
                                   input logic [ldrst_pkg::THR_W-1:0] thr);
    logic [ldrst_pkg::AVG_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

  function automatic logic [ldrst_pkg::ANGLE_W-1:0] move_axis(
      input logic [ldrst_pkg::ANGLE_W-1:0] angle,
      input logic [ldrst_pkg::AVG_W-1:0]   a,
      input logic [ldrst_pkg::AVG_W-1:0]   b,
      input logic [ldrst_pkg::AVG_W-1:0]   c,
      input logic [ldrst_pkg::AVG_W-1:0]   d,
      input ldrst_pkg::cfg_t               cf);
    logic                            moved;
    logic                            down;
    logic [ldrst_pkg::ANGLE_W:0]     up_sum;
    logic [ldrst_pkg::ANGLE_W-1:0]   result;
    moved  = 1'b0;
    down   = 1'b0;
    result = angle;
    priority if (exceeds(a, b, cf.threshold)) begin
      moved = 1'b1;
      down  = a > b;
    end else if (exceeds(c, d, cf.threshold)) begin
      moved = 1'b1;
      down  = c > d;
    end else begin
      // hold the angle
      moved = 1'b0;
      down  = 1'b0;
    end
    up_sum = {1'b0, angle} + (ldrst_pkg::ANGLE_W + 1)'(cf.step_degrees);
    if (moved) begin
      if (down) begin
        // clamp at zero
        result = (ldrst_pkg::ANGLE_W'(cf.step_degrees) > angle) ? '0
               : angle - ldrst_pkg::ANGLE_W'(cf.step_degrees);
      end else begin
        result = (up_sum > (ldrst_pkg::ANGLE_W + 1)'(ldrst_pkg::ANGLE_MAX))
               ? ldrst_pkg::ANGLE_MAX : up_sum[ldrst_pkg::ANGLE_W-1:0];
      end
    end
    // a position above the limit never occurs, but keep the clamp complete
    if (result > ldrst_pkg::ANGLE_MAX) result = ldrst_pkg::ANGLE_MAX;
    return result;
  endfunction

  assign q_pop = q_valid && (!res_valid || res_ready);

  assign vert_next = move_axis(vert_pos, q_data.avg_one, q_data.avg_two,
                               q_data.avg_three, q_data.avg_four, cfg);
  assign horz_next = move_axis(horz_pos, q_data.avg_one, q_data.avg_three,
                               q_data.avg_two, q_data.avg_four, cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_pos  <= ldrst_pkg::ANGLE_RESET;
      horz_pos  <= ldrst_pkg::ANGLE_RESET;
      res_valid <= 1'b0;
    end else if (q_pop) begin
      vert_pos  <= vert_next;
      horz_pos  <= horz_next;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.avgs       <= q_data;
      res.vertical   <= vert_next;
      res.horizontal <= horz_next;
    end
  end

endmodule

// ===== src/ldr_solar_tracker_step_unit.sv =====
// Top level of the light-sensor solar tracker step unit: configuration
// registers, front end, queue and back end. Uses ldrst_pkg and the ldrst_* modules.
//
// Usage:
//   Input stream (s_*): one transfer carries one sample from each of four
//   light sensors. Every SAMPLES transfers close a batch.
//   Output stream (m_*): one transfer per batch with the four averages and
//   the updated vertical and horizontal servo angles (0..180 degrees).
//   Config port: cfg_we with cfg_index 0 writes threshold, 1 writes
//   step_degrees; write only while no batch is in flight.
// Throughput: one input transfer per cycle while s_tready is high; accumulation
//   is one add per channel per cycle and the angles are updated once per batch.
// Result path: the averages of a batch enter the queue with its last input
//   transfer and pass from there into the output register.
// Reset (rst, synchronous): sums and count clear, both angles go to 90,
//   threshold to 100, step to 10, the queue empties.
// Stall: while m_tready is low the result holds; the two-entry queue
//   absorbs further batches, and s_tready drops only when it is full.
module ldr_solar_tracker_step_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata: sample_one[11:0], sample_two[23:12], sample_three[35:24], sample_four[47:36]
  input  logic [ldrst_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata: average_one[11:0], average_two[23:12], average_three[35:24],
  //          average_four[47:36], vertical_angle[55:48], horizontal_angle[63:56]
  output logic [ldrst_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                  cfg_we,
  input  logic [ldrst_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ldrst_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ldrst_pkg::cfg_t     cfg;
  ldrst_pkg::avg_set_t push_data;
  ldrst_pkg::avg_set_t pop_data;
  ldrst_pkg::result_t  res;
  logic                q_full;
  logic                q_push;
  logic                q_valid;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= ldrst_pkg::THR_RESET;
      cfg.step_degrees <= ldrst_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldrst_pkg::REG_THRESHOLD: cfg.threshold    <= cfg_data[ldrst_pkg::THR_W-1:0];
        ldrst_pkg::REG_STEP:      cfg.step_degrees <= cfg_data[ldrst_pkg::STEP_W-1:0];
        default:                  cfg              <= cfg;
      endcase
    end
  end

  ldrst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  ldrst_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_data)
  );

  ldrst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.horizontal, res.vertical, res.avgs.avg_four,
                    res.avgs.avg_three, res.avgs.avg_two, res.avgs.avg_one};

endmodule

// ===== src/ldrst_checker.sv =====
// Port-level checks for the solar tracker step unit, bound to the top level.
// Uses ldrst_pkg for widths and the angle limit.
module ldrst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [ldrst_pkg::OUT_DATA_W-1:0]    m_tdata
);

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // queue empties on reset, so input is open the next cycle
  a_reset_opens_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // both angles stay within the servo range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[55:48] <= ldrst_pkg::ANGLE_MAX)
                && (m_tdata[63:56] <= ldrst_pkg::ANGLE_MAX))
    else $error("angle out of range");

endmodule

bind ldr_solar_tracker_step_unit ldrst_checker u_ldrst_checker (.*);
